@@ sv/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// Table geometry, request and status codes, and the control word that the
// top level hands to every cell.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Table geometry.
  localparam int Capacity = 64;
  localparam int ValueW   = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  // Per-request increment of the running totals (at most Capacity).
  localparam int IncW     = CntW + 1;
  localparam int TotW     = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Control word broadcast to all cells.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the operand
    logic ins_en;  // open a slot at the insert position and write the operand
    logic rem_en;  // close the slot of the first match
  } cell_ctl_t;

endpackage

@@ sv/slt_cell.sv @@
// ----------------------------------------------------------------------------
// slt_cell: one slot of the sorted list table
// Holds one entry, compares it against the operand, and takes its left or
// right neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
module slt_cell import slt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctl_t                ctl_i,
  input  logic                     valid_i,
  input  logic signed [ValueW-1:0] operand_i,
  input  logic                     prev_le_i,
  input  logic signed [ValueW-1:0] prev_entry_i,
  input  logic signed [ValueW-1:0] next_entry_i,
  output logic signed [ValueW-1:0] entry_o,
  output logic                     lt_o,
  output logic                     le_o
);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     lt_q, le_q;

  // Compare flags: entry below operand, and entry not above operand.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      le_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      lt_q <= valid_i && (entry_q < operand_i);
      le_q <= valid_i && (entry_q <= operand_i);
    end
  end

  // Shift logic. Since the table is sorted, the flags of this cell and its
  // left neighbor tell whether this slot lies above, at or below the
  // insert position, and whether it lies at or above the removed slot.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en) begin
      if (!prev_le_i) begin
        entry_d = prev_entry_i;
      end else if (!le_q) begin
        entry_d = operand_i;
      end
    end else if (ctl_i.rem_en) begin
      if (!lt_q) begin
        entry_d = next_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign le_o    = le_q;

endmodule

@@ sv/sorted_list_table.sv @@
// ----------------------------------------------------------------------------
// sorted_list_table: signed values kept in ascending order in a row of cells
// Each request takes a compare phase, then an update phase that registers
// the result; a new request can be accepted during the update phase.
// The result cannot be stalled; it is shown for one cycle with done_o.
// Reset clears the count and both totals at once; entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_table import slt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [ValueW-1:0] result_value_o,
  output logic [IdxW-1:0]          result_index_o,
  output logic [CntW-1:0]          item_count_o,
  output logic                     is_full_o,
  output logic                     is_empty_o,
  output logic [TotW-1:0]          comparisons_o,
  output logic [TotW-1:0]          moves_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } phase_e;

  phase_e                   phase_q;
  func_e                    op_q;
  logic signed [ValueW-1:0] operand_q;
  logic [CntW-1:0]          count_q, count_d;
  logic [TotW-1:0]          cmp_total_q, cmp_total_d;
  logic [TotW-1:0]          mov_total_q, mov_total_d;
  logic                     done_q;
  logic [1:0]               status_q;
  logic signed [ValueW-1:0] rval_q;
  logic [IdxW-1:0]          ridx_q;

  logic                     accept;
  cell_ctl_t                ctl;

  logic signed [ValueW-1:0] entry_vec [Capacity];
  logic [Capacity-1:0]      lt_vec, le_vec, valid_vec, prev_le, prev_lt;

  logic [IdxW-1:0]          ins_pos, match_pos;
  logic                     found, all_lt, all_le;

  status_e                  status_d;
  logic signed [ValueW-1:0] rval_d;
  logic [IdxW-1:0]          ridx_d;
  logic [IncW-1:0]          cmp_inc, mov_inc;
  logic                     ins_ok, rem_ok;
  logic [TotW:0]            cmp_sum, mov_sum;

  assign busy   = (phase_q == PH_CMP);
  assign accept = start && !busy;

  assign ctl.cmp_en = (phase_q == PH_CMP);
  assign ctl.ins_en = (phase_q == PH_UPD) && ins_ok;
  assign ctl.rem_en = (phase_q == PH_UPD) && rem_ok;

  // Row of cells, each wired to its neighbors.
  for (genvar j = 0; j < Capacity; j++) begin : g_cell
    assign valid_vec[j] = CntW'(j) < count_q;
    if (j == 0) begin : g_first
      assign prev_le[j] = 1'b1;
      assign prev_lt[j] = 1'b1;
    end else begin : g_rest
      assign prev_le[j] = le_vec[j-1];
      assign prev_lt[j] = lt_vec[j-1];
    end

    slt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .valid_i      (valid_vec[j]),
      .operand_i    (operand_q),
      .prev_le_i    (prev_le[j]),
      .prev_entry_i ((j == 0) ? entry_vec[0] : entry_vec[(j == 0) ? 0 : j-1]),
      .next_entry_i (entry_vec[(j == Capacity-1) ? j : j+1]),
      .entry_o      (entry_vec[j]),
      .lt_o         (lt_vec[j]),
      .le_o         (le_vec[j])
    );
  end

  // Position encoding. The flags form a run of ones from slot zero, so the
  // edge of each run is one-hot and an OR over the slot numbers encodes it.
  always_comb begin
    ins_pos   = '0;
    match_pos = '0;
    found     = 1'b0;
    for (int j = 0; j < Capacity; j++) begin
      if (prev_le[j] && !le_vec[j]) begin
        ins_pos = ins_pos | IdxW'(j);
      end
      if (prev_lt[j] && !lt_vec[j]) begin
        match_pos = match_pos | IdxW'(j);
        found     = found | le_vec[j];
      end
    end
  end

  assign all_lt = &(lt_vec | ~valid_vec);
  assign all_le = &(le_vec | ~valid_vec);

  // Request decode for the update cycle.
  always_comb begin
    status_d = ST_OK;
    rval_d   = '0;
    ridx_d   = '0;
    cmp_inc  = '0;
    mov_inc  = '0;
    count_d  = count_q;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    case (op_q)
      FUNC_INSERT: begin
        if (count_q == CntW'(Capacity)) begin
          status_d = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          ridx_d  = ins_pos;
          count_d = count_q + 1'b1;
          mov_inc = IncW'(count_q) - IncW'(ins_pos) + IncW'(1);
          if (all_le) begin
            // An append past a smaller last item makes no comparison.
            cmp_inc = all_lt ? '0 : IncW'(count_q);
          end else begin
            cmp_inc = IncW'(ins_pos) + IncW'(1);
          end
        end
      end
      FUNC_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
          cmp_inc  = IncW'(count_q);
        end else begin
          rem_ok  = 1'b1;
          rval_d  = operand_q;
          ridx_d  = match_pos;
          count_d = count_q - 1'b1;
          cmp_inc = IncW'(match_pos) + IncW'(1);
          mov_inc = IncW'(count_q) - IncW'(match_pos);
        end
      end
      FUNC_FIND: begin
        if (found) begin
          ridx_d  = match_pos;
          cmp_inc = IncW'(match_pos) + IncW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
          cmp_inc  = IncW'(count_q);
        end
      end
      FUNC_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Saturating running totals.
  assign cmp_sum     = {1'b0, cmp_total_q} + (TotW+1)'(cmp_inc);
  assign mov_sum     = {1'b0, mov_total_q} + (TotW+1)'(mov_inc);
  assign cmp_total_d = cmp_sum[TotW] ? '1 : cmp_sum[TotW-1:0];
  assign mov_total_d = mov_sum[TotW] ? '1 : mov_sum[TotW-1:0];

  // Phase sequencer, table state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op_q        <= FUNC_INSERT;
      operand_q   <= '0;
      count_q     <= '0;
      cmp_total_q <= '0;
      mov_total_q <= '0;
      done_q      <= 1'b0;
      status_q    <= '0;
      rval_q      <= '0;
      ridx_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        op_q      <= func_e'(func_i);
        operand_q <= value_i;
      end
      case (phase_q)
        PH_IDLE: begin
          if (accept) begin
            phase_q <= PH_CMP;
          end
        end
        PH_CMP: begin
          phase_q <= PH_UPD;
        end
        PH_UPD: begin
          phase_q     <= accept ? PH_CMP : PH_IDLE;
          count_q     <= count_d;
          cmp_total_q <= cmp_total_d;
          mov_total_q <= mov_total_d;
          done_q      <= 1'b1;
          status_q    <= status_d;
          rval_q      <= rval_d;
          ridx_q      <= ridx_d;
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_value_o = rval_q;
  assign result_index_o = ridx_q;
  assign item_count_o   = count_q;
  assign is_full_o      = (count_q == CntW'(Capacity));
  assign is_empty_o     = (count_q == '0);
  assign comparisons_o  = cmp_total_q;
  assign moves_o        = mov_total_q;

endmodule

@@ sv/slt_checker.sv @@
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the sorted list table
// Watches request timing, result timing and the consistency of the reported
// count and totals.
// ----------------------------------------------------------------------------
module slt_checker import slt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic [CntW-1:0]          item_count_o,
  input logic                     is_full_o,
  input logic                     is_empty_o,
  input logic [TotW-1:0]          comparisons_o,
  input logic [TotW-1:0]          moves_o
);

  // An accepted request blocks the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // Every accepted request yields its result after its compare and update phases.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing after an accepted request");

  // The totals change only together with a result.
  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> ($stable(comparisons_o) && $stable(moves_o)))
    else $error("running totals changed without a result");

  // Full and empty flags agree with the count, which stays in range.
  a_count_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((item_count_o <= CntW'(Capacity))
      && (is_full_o == (item_count_o == CntW'(Capacity)))
      && (is_empty_o == (item_count_o == '0))))
    else $error("count and full or empty flags disagree");

endmodule

bind sorted_list_table slt_checker u_slt_checker (.*);
